@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Expects i_clk and i_rst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/zsba_pkg.sv @@
// Shared types and constants of the zone stream block allocator.
// No dependencies.
package zsba_pkg;

    localparam int BLOCK_COUNT    = 8;
    localparam int BLK_W          = 3;
    localparam int STACK_CAPACITY = 64;
    localparam int STACK_AW       = 6;
    localparam int FRAME_CNT_W    = 7;
    localparam int FRAME_W        = 38;
    localparam int QUEUE_CAPACITY = 1024;
    localparam int QUEUE_AW       = 10;
    localparam int SPAN_CNT_W     = 11;
    localparam int QENTRY_W       = 67;
    localparam int TOTAL_W        = 35;

    typedef logic [3:0] t_opcode;
    localparam t_opcode OP_INIT     = 4'd0;
    localparam t_opcode OP_PUSH     = 4'd1;
    localparam t_opcode OP_POP      = 4'd2;
    localparam t_opcode OP_PLAN     = 4'd3;
    localparam t_opcode OP_RESERVE  = 4'd4;
    localparam t_opcode OP_REPLAY   = 4'd5;
    localparam t_opcode OP_PEEK     = 4'd6;
    localparam t_opcode OP_CONSUME  = 4'd7;
    localparam t_opcode OP_VALIDATE = 4'd8;
    localparam t_opcode OP_READ     = 4'd9;

    typedef logic [3:0] t_err;
    localparam t_err ERR_NONE       = 4'd0;
    localparam t_err ERR_NOT_INIT   = 4'd1;
    localparam t_err ERR_INVALID    = 4'd2;
    localparam t_err ERR_ARENA      = 4'd3;
    localparam t_err ERR_OVERFLOW   = 4'd4;
    localparam t_err ERR_STACK      = 4'd5;
    localparam t_err ERR_UNDERFLOW  = 4'd6;
    localparam t_err ERR_REPLAY     = 4'd7;
    localparam t_err ERR_SPAN_LIM   = 4'd8;
    localparam t_err ERR_BYTE_LIM   = 4'd9;
    localparam t_err ERR_CONSUME    = 4'd10;
    localparam t_err ERR_UNBALANCED = 4'd11;
    localparam t_err ERR_SIZE       = 4'd12;
    localparam t_err ERR_INCOMPLETE = 4'd13;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_IMMEDIATE = 2'd0;
    localparam t_kind KIND_ZERO_FILL = 2'd1;
    localparam t_kind KIND_DELAYED   = 2'd2;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SIZES_0_1 = 3'd0;
    localparam t_cfg_idx CFG_SIZES_2_3 = 3'd1;
    localparam t_cfg_idx CFG_SIZES_4_5 = 3'd2;
    localparam t_cfg_idx CFG_SIZES_6_7 = 3'd3;
    localparam t_cfg_idx CFG_STACK     = 3'd4;
    localparam t_cfg_idx CFG_SPANS     = 3'd5;
    localparam t_cfg_idx CFG_BYTES     = 3'd6;
    localparam t_cfg_idx CFG_ARENA     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ALIGN,
        ST_SWEEP,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic read;
        logic align;
        logic sweep;
        logic exec;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic op_plan;
        logic op_sweep;
        logic sweep_last;
        logic out_busy;
    } t_status;

endpackage

@@ rtl/core/zsba_ctrl.sv @@
// Sequencer of the allocator: steps one word through read, align (plan, reserve)
// or sweep (init, validate), execute and output. Depends on zsba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zsba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  zsba_pkg::t_status i_status,
    output zsba_pkg::t_cmd   o_cmd
);
    import zsba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_READ;
            end
            ST_READ: begin
                if (i_status.op_plan) n_state = ST_ALIGN;
                else if (i_status.op_sweep) n_state = ST_SWEEP;
                else n_state = ST_EXEC;
            end
            ST_ALIGN: n_state = ST_EXEC;
            ST_SWEEP: begin
                if (i_status.sweep_last) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = (r_state == ST_IDLE);
        o_cmd.capture    = (r_state == ST_IDLE) && i_valid;
        o_cmd.read       = (r_state == ST_READ);
        o_cmd.align      = (r_state == ST_ALIGN);
        o_cmd.sweep      = (r_state == ST_SWEEP);
        o_cmd.exec       = (r_state == ST_EXEC);
        o_cmd.load_out   = (r_state == ST_DONE) && !i_status.out_busy;
    end

    `ASSERT_NEXT(a_exec_then_done, r_state == ST_EXEC, r_state == ST_DONE, "exec not followed by done")
    `ASSERT_NEXT(a_load_idle, o_cmd.load_out, r_state == ST_IDLE, "result load did not free the block")
    `ASSERT_IMPLIES(a_one_cmd, 1'b1, $countones(o_cmd) <= 1, "more than one command at once")

endmodule

@@ rtl/core/zsba_dp.sv @@
// Datapath of the allocator: config and latched limits, cursors, frame
// stack and span queue memories, result register. Depends on zsba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zsba_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  zsba_pkg::t_cmd           i_cmd,
    output zsba_pkg::t_status        o_status,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [63:0]              i_cfg_data,
    input  logic [3:0]               i_opcode,
    input  logic [3:0]               i_block,
    input  logic [31:0]              i_alignment,
    input  logic [32:0]              i_length,
    input  logic [9:0]               i_span_index,
    input  logic                     i_ready,
    output logic                     o_valid,
    output logic [3:0]               o_error,
    output logic                     o_found,
    output logic [2:0]               o_span_block,
    output logic [31:0]              o_span_offset,
    output logic [31:0]              o_span_length,
    output logic [1:0]               o_load_kind,
    output logic [2:0]               o_active_block,
    output logic [6:0]               o_stack_level,
    output logic [10:0]              o_queued_spans,
    output logic                     o_replay_done
);
    import zsba_pkg::*;

    // configuration
    logic [63:0] r_cfg_size [4];
    logic [7:0]  r_cfg_stack;
    logic [15:0] r_cfg_spans;
    logic [63:0] r_cfg_bytes;
    logic [63:0] r_cfg_arena;

    // latched at init
    logic [31:0]            r_lat_size [BLOCK_COUNT];
    logic [FRAME_CNT_W-1:0] r_lat_stack;
    logic [SPAN_CNT_W-1:0]  r_lat_spans;
    logic [63:0]            r_lat_bytes;

    // allocator state
    logic [31:0]            r_cur [BLOCK_COUNT];
    logic [31:0]            r_hwm [BLOCK_COUNT];
    logic [BLK_W-1:0]       r_cur_blk;
    logic [FRAME_CNT_W-1:0] r_frames;
    logic [SPAN_CNT_W-1:0]  r_spans;
    logic [63:0]            r_qbytes;
    logic [SPAN_CNT_W-1:0]  r_rpos;
    logic [31:0]            r_roff;
    logic                   r_ractive;
    logic                   r_init_done;

    // memories
    logic [FRAME_W-1:0]  r_frame_mem [STACK_CAPACITY];
    logic [QENTRY_W-1:0] r_queue_mem [QUEUE_CAPACITY];
    logic [FRAME_W-1:0]  r_frame_rd;
    logic [QENTRY_W-1:0] r_queue_rd;

    // captured word
    t_opcode     r_op;
    logic [3:0]  r_blk;
    logic [31:0] r_align;
    logic [32:0] r_len;
    logic [9:0]  r_sidx;

    // working registers
    logic [31:0]        r_cur_rd;
    logic [31:0]        r_hwm_rd;
    logic [31:0]        r_size_rd;
    logic [32:0]        r_aligned;
    logic [BLK_W-1:0]   r_cnt;
    logic [TOTAL_W-1:0] r_total;
    logic               r_mismatch;

    // step results
    t_err        r_res_err;
    logic        r_res_found;
    logic [2:0]  r_res_sb;
    logic [31:0] r_res_so;
    logic [31:0] r_res_sl;
    t_kind       r_res_kind;
    logic        r_o_valid;

    t_err        n_err;
    logic        n_found;
    logic [2:0]  n_sb;
    logic [31:0] n_so;
    logic [31:0] n_sl;
    t_kind       n_kind;

    logic do_init, do_push, do_pop, do_commit, do_enq, do_replay, do_consume;

    logic [BLK_W-1:0]    rd_addr;
    logic [STACK_AW-1:0] frame_ra;
    logic [QUEUE_AW-1:0] queue_ra;
    logic [31:0]         cfg_size_c;
    logic                sweep_ok;
    logic [31:0]         mask;
    logic                align_bad;
    logic [32:0]         decl33;
    logic                ovf;
    t_kind               kind_c;
    logic                span_full;
    logic                byte_full;
    logic [63:0]         byte_room;
    logic [31:0]         q_off;
    logic [31:0]         q_len;
    logic [2:0]          q_blk;
    logic [31:0]         rem;
    logic [31:0]         roff_new;
    logic [31:0]         commit_val;
    logic                replay_done_c;

    assign rd_addr  = i_cmd.sweep ? r_cnt
                    : ((r_op == OP_PUSH) ? r_blk[BLK_W-1:0] : r_cur_blk);
    assign frame_ra = r_frames[STACK_AW-1:0] - STACK_AW'(1);
    assign queue_ra = ((r_op == OP_PEEK) || (r_op == OP_CONSUME))
                    ? r_rpos[QUEUE_AW-1:0] : r_sidx;
    assign cfg_size_c = r_cnt[0] ? r_cfg_size[r_cnt[2:1]][63:32]
                                 : r_cfg_size[r_cnt[2:1]][31:0];
    assign sweep_ok = ((r_cnt == '0) ? (r_cur[rd_addr] == '0)
                                     : (r_cur[rd_addr] == r_lat_size[rd_addr]))
                    && (r_hwm[rd_addr] == r_lat_size[rd_addr]);

    assign mask      = r_align - 32'd1;
    assign align_bad = (r_align == '0) || ((r_align & mask) != '0) || r_len[32];
    assign decl33    = {1'b0, r_size_rd};
    assign ovf       = (r_aligned > decl33) || (r_len > (decl33 - r_aligned));
    assign byte_room = r_lat_bytes - r_qbytes;
    assign span_full = (r_spans >= r_lat_spans) || r_spans[SPAN_CNT_W-1];
    assign byte_full = (r_qbytes > r_lat_bytes) || ({31'd0, r_len} > byte_room);
    assign commit_val = r_aligned[31:0] + r_len[31:0];

    assign q_blk = r_queue_rd[66:64];
    assign q_off = r_queue_rd[63:32];
    assign q_len = r_queue_rd[31:0];
    assign rem      = q_len - r_roff;
    assign roff_new = r_roff + r_len[31:0];
    assign replay_done_c = r_ractive && (r_rpos == r_spans);

    always_comb begin
        unique case (r_cur_blk)
            3'd1:       kind_c = KIND_ZERO_FILL;
            3'd2, 3'd3: kind_c = KIND_DELAYED;
            default:    kind_c = KIND_IMMEDIATE;
        endcase
    end

    always_comb begin
        o_status.op_plan    = (r_op == OP_PLAN) || (r_op == OP_RESERVE);
        o_status.op_sweep   = (r_op == OP_INIT) || (r_op == OP_VALIDATE);
        o_status.sweep_last = (r_cnt == BLK_W'(BLOCK_COUNT - 1));
        o_status.out_busy   = r_o_valid && !i_ready;
    end

    always_comb begin
        n_err = ERR_NONE;
        n_found = 1'b0;
        n_sb = '0;
        n_so = '0;
        n_sl = '0;
        n_kind = KIND_IMMEDIATE;
        do_init = 1'b0;
        do_push = 1'b0;
        do_pop = 1'b0;
        do_commit = 1'b0;
        do_enq = 1'b0;
        do_replay = 1'b0;
        do_consume = 1'b0;
        unique case (r_op)
            OP_INIT: begin
                if ((r_cfg_stack > 8'(STACK_CAPACITY))
                    || (r_cfg_spans > 16'(QUEUE_CAPACITY))) n_err = ERR_INVALID;
                else if ({29'd0, r_total} > r_cfg_arena) n_err = ERR_ARENA;
                else do_init = 1'b1;
            end
            OP_PUSH: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if (r_ractive) n_err = ERR_REPLAY;
                else if (r_blk[3]) n_err = ERR_INVALID;
                else if ((r_frames >= r_lat_stack) || r_frames[FRAME_CNT_W-1])
                    n_err = ERR_STACK;
                else do_push = 1'b1;
            end
            OP_POP: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if (r_ractive) n_err = ERR_REPLAY;
                else if (r_frames == '0) n_err = ERR_UNDERFLOW;
                else if (r_frame_rd[34:32] != r_cur_blk) n_err = ERR_UNBALANCED;
                else do_pop = 1'b1;
            end
            OP_PLAN, OP_RESERVE: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if (r_ractive) n_err = ERR_REPLAY;
                else if (align_bad) n_err = ERR_INVALID;
                else if (ovf) n_err = ERR_OVERFLOW;
                else if ((r_op == OP_PLAN) && (kind_c == KIND_DELAYED) && (r_len != '0)
                         && span_full) n_err = ERR_SPAN_LIM;
                else if ((r_op == OP_PLAN) && (kind_c == KIND_DELAYED) && (r_len != '0)
                         && byte_full) n_err = ERR_BYTE_LIM;
                else begin
                    do_commit = 1'b1;
                    do_enq = (r_op == OP_PLAN) && (kind_c == KIND_DELAYED) && (r_len != '0);
                    n_sb = r_cur_blk;
                    n_so = r_aligned[31:0];
                    n_sl = r_len[31:0];
                    n_kind = (r_op == OP_PLAN) ? kind_c : KIND_IMMEDIATE;
                end
            end
            OP_REPLAY: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if (r_ractive) n_err = ERR_REPLAY;
                else if ((r_frames != '0) || (r_cur_blk != '0)) n_err = ERR_UNBALANCED;
                else do_replay = 1'b1;
            end
            OP_PEEK: begin
                if (r_ractive && (r_rpos < r_spans) && !r_rpos[SPAN_CNT_W-1]) begin
                    n_found = 1'b1;
                    n_sb = q_blk;
                    n_so = q_off + r_roff;
                    n_sl = rem;
                end
            end
            OP_CONSUME: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if (!r_ractive) n_err = ERR_REPLAY;
                else if ((r_len == '0) || (r_rpos >= r_spans) || r_rpos[SPAN_CNT_W-1])
                    n_err = ERR_CONSUME;
                else if (r_len > {1'b0, rem}) n_err = ERR_CONSUME;
                else do_consume = 1'b1;
            end
            OP_VALIDATE: begin
                if (!r_init_done) n_err = ERR_NOT_INIT;
                else if ((r_frames != '0) || (r_cur_blk != '0)) n_err = ERR_UNBALANCED;
                else if ((r_spans != '0) && !replay_done_c) n_err = ERR_INCOMPLETE;
                else if (r_mismatch) n_err = ERR_SIZE;
            end
            OP_READ: begin
                if ({1'b0, r_sidx} < r_spans) begin
                    n_found = 1'b1;
                    n_sb = q_blk;
                    n_so = q_off;
                    n_sl = q_len;
                end
            end
            default: n_err = ERR_INVALID;
        endcase
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_cfg_size[i] <= '0;
            r_cfg_stack <= '0;
            r_cfg_spans <= '0;
            r_cfg_bytes <= '0;
            r_cfg_arena <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIZES_0_1: r_cfg_size[0] <= i_cfg_data;
                CFG_SIZES_2_3: r_cfg_size[1] <= i_cfg_data;
                CFG_SIZES_4_5: r_cfg_size[2] <= i_cfg_data;
                CFG_SIZES_6_7: r_cfg_size[3] <= i_cfg_data;
                CFG_STACK:     r_cfg_stack <= i_cfg_data[7:0];
                CFG_SPANS:     r_cfg_spans <= i_cfg_data[15:0];
                CFG_BYTES:     r_cfg_bytes <= i_cfg_data;
                CFG_ARENA:     r_cfg_arena <= i_cfg_data;
                default:       r_cfg_arena <= r_cfg_arena;
            endcase
        end
    end

    // word capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_blk   <= i_block;
            r_align <= i_alignment;
            r_len   <= i_length;
            r_sidx  <= i_span_index;
        end
        if (i_cmd.read) begin
            r_cur_rd   <= r_cur[rd_addr];
            r_hwm_rd   <= r_hwm[rd_addr];
            r_size_rd  <= r_lat_size[rd_addr];
            r_cnt      <= '0;
            r_total    <= '0;
            r_mismatch <= 1'b0;
        end
        if (i_cmd.align) begin
            r_aligned <= ({1'b0, r_cur_rd} + {1'b0, mask}) & ~{1'b0, mask};
        end
        if (i_cmd.sweep) begin
            r_total    <= r_total + TOTAL_W'(cfg_size_c);
            r_mismatch <= r_mismatch || !sweep_ok;
            r_cnt      <= r_cnt + BLK_W'(1);
        end
        if (i_cmd.exec) begin
            r_res_err   <= n_err;
            r_res_found <= n_found;
            r_res_sb    <= n_sb;
            r_res_so    <= n_so;
            r_res_sl    <= n_sl;
            r_res_kind  <= n_kind;
        end
    end

    // frame stack and span queue
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_frame_rd <= r_frame_mem[frame_ra];
            r_queue_rd <= r_queue_mem[queue_ra];
        end
        if (i_cmd.exec && do_push) begin
            r_frame_mem[r_frames[STACK_AW-1:0]] <= {r_cur_blk, r_blk[BLK_W-1:0], r_cur_rd};
        end
        if (i_cmd.exec && do_enq) begin
            r_queue_mem[r_spans[QUEUE_AW-1:0]] <= {r_cur_blk, r_aligned[31:0], r_len[31:0]};
        end
    end

    // allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                r_cur[i]      <= '0;
                r_hwm[i]      <= '0;
                r_lat_size[i] <= '0;
            end
            r_lat_stack <= '0;
            r_lat_spans <= '0;
            r_lat_bytes <= '0;
            r_cur_blk   <= '0;
            r_frames    <= '0;
            r_spans     <= '0;
            r_qbytes    <= '0;
            r_rpos      <= '0;
            r_roff      <= '0;
            r_ractive   <= 1'b0;
            r_init_done <= 1'b0;
        end else if (i_cmd.exec) begin
            if (do_init) begin
                for (int i = 0; i < BLOCK_COUNT; i++) begin
                    r_cur[i]      <= '0;
                    r_hwm[i]      <= '0;
                    r_lat_size[i] <= (i % 2 == 1) ? r_cfg_size[i / 2][63:32]
                                                  : r_cfg_size[i / 2][31:0];
                end
                r_lat_stack <= r_cfg_stack[FRAME_CNT_W-1:0];
                r_lat_spans <= r_cfg_spans[SPAN_CNT_W-1:0];
                r_lat_bytes <= r_cfg_bytes;
                r_cur_blk   <= '0;
                r_frames    <= '0;
                r_spans     <= '0;
                r_qbytes    <= '0;
                r_rpos      <= '0;
                r_roff      <= '0;
                r_ractive   <= 1'b0;
                r_init_done <= 1'b1;
            end
            if (do_push) begin
                r_frames  <= r_frames + FRAME_CNT_W'(1);
                r_cur_blk <= r_blk[BLK_W-1:0];
            end
            if (do_pop) begin
                if (r_cur_blk == '0) r_cur[0] <= r_frame_rd[31:0];
                r_cur_blk <= r_frame_rd[37:35];
                r_frames  <= r_frames - FRAME_CNT_W'(1);
            end
            if (do_commit) begin
                r_cur[r_cur_blk] <= commit_val;
                if (commit_val > r_hwm_rd) r_hwm[r_cur_blk] <= commit_val;
            end
            if (do_enq) begin
                r_spans  <= r_spans + SPAN_CNT_W'(1);
                r_qbytes <= r_qbytes + {31'd0, r_len};
            end
            if (do_replay) begin
                r_ractive <= 1'b1;
                r_rpos    <= '0;
                r_roff    <= '0;
            end
            if (do_consume) begin
                if (roff_new == q_len) begin
                    r_rpos <= r_rpos + SPAN_CNT_W'(1);
                    r_roff <= '0;
                end else begin
                    r_roff <= roff_new;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_error        <= r_res_err;
            o_found        <= r_res_found;
            o_span_block   <= r_res_sb;
            o_span_offset  <= r_res_so;
            o_span_length  <= r_res_sl;
            o_load_kind    <= r_res_kind;
            o_active_block <= r_cur_blk;
            o_stack_level  <= r_frames;
            o_queued_spans <= r_spans;
            o_replay_done  <= replay_done_c;
        end
    end

    assign o_valid = r_o_valid;

    `ASSERT_ALWAYS(a_frames_cap, r_frames <= FRAME_CNT_W'(STACK_CAPACITY), "frame count above capacity")
    `ASSERT_ALWAYS(a_spans_cap, r_spans <= SPAN_CNT_W'(QUEUE_CAPACITY), "span count above capacity")
    `ASSERT_IMPLIES(a_rpos_bound, r_ractive, r_rpos <= r_spans, "replay past queued spans")
    `ASSERT_IMPLIES(a_roff_bound, r_ractive && (r_rpos == r_spans), r_roff == '0, "offset left after last span")

endmodule

@@ rtl/core/zone_stream_block_allocator.sv @@
// Top level of the zone stream block allocator.
// Instantiates zsba_ctrl and zsba_dp; depends on zsba_pkg.
//
// Each input word carries one opcode and yields exactly one result word.
// A word passes through capture, memory/cursor read, execute and result
// load for most opcodes; plan load and reserve add a cursor alignment
// stage after the read, and init and validate instead sweep the eight blocks
// one per cycle. A new word is taken once the previous result sits in
// the output register, so the result may wait there while the next word
// is processed. Configuration words are latched only by a successful init.
module zone_stream_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_opcode,
    input  logic [3:0]  i_block,
    input  logic [31:0] i_alignment,
    input  logic [32:0] i_length,
    input  logic [9:0]  i_span_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_error,
    output logic        o_found,
    output logic [2:0]  o_span_block,
    output logic [31:0] o_span_offset,
    output logic [31:0] o_span_length,
    output logic [1:0]  o_load_kind,
    output logic [2:0]  o_active_block,
    output logic [6:0]  o_stack_level,
    output logic [10:0] o_queued_spans,
    output logic        o_replay_done,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import zsba_pkg::*;

    t_cmd    cmd;
    t_status status;

    zsba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    zsba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_block        (i_block),
        .i_alignment    (i_alignment),
        .i_length       (i_length),
        .i_span_index   (i_span_index),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_error        (o_error),
        .o_found        (o_found),
        .o_span_block   (o_span_block),
        .o_span_offset  (o_span_offset),
        .o_span_length  (o_span_length),
        .o_load_kind    (o_load_kind),
        .o_active_block (o_active_block),
        .o_stack_level  (o_stack_level),
        .o_queued_spans (o_queued_spans),
        .o_replay_done  (o_replay_done)
    );

endmodule
